### design/gyro_bias_calibration_deadband_top_macros.svh
// ----------------------------------------------------------------------------
// gyro bias calibration assertion macros
// short forms for the concurrent checks of the top level, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef GYRO_BIAS_CALIBRATION_DEADBAND_TOP_MACROS_SVH
`define GYRO_BIAS_CALIBRATION_DEADBAND_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GBCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GBCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gbcd_pkg.sv
// ----------------------------------------------------------------------------
// gbcd_pkg
// shared widths, codes, scale table and unit interface types
// ----------------------------------------------------------------------------
package gbcd_pkg;

    localparam int NUM_AXES  = 3;
    localparam int AX_W      = 2;
    localparam int RAW_W     = 16;
    localparam int SUM_W     = 25;
    localparam int MAG_W     = 24;
    localparam int SQ_W      = 39;
    localparam int CNT_W     = 8;
    localparam int RATE_W    = 29;
    localparam int SCALE_W   = 12;
    localparam int THR_W     = 24;
    localparam int VAR_W     = 32;
    localparam int DATA_W    = 48;
    localparam int ACC_W     = 50;
    localparam int STEP_W    = 6;
    localparam int CFG_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int S_TDATA_W = ((NUM_AXES * RAW_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NUM_AXES * RATE_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CALIB_SAMPLES_RESET = 8'd50;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_CALIB_SAMPLES = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_SCALE    = 2'd2;

    typedef enum logic [1:0] {
        ACT_CAL     = 2'd0,
        ACT_MEAS    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } unit_op_t;

    typedef struct packed {
        logic              start;
        unit_op_t          op;
        logic [DATA_W-1:0] opa;
        logic [DATA_W-1:0] opb;
    } unit_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ACC_W-1:0]  acc;
        logic [DATA_W-1:0] quo;
    } unit_stat_t;

    // degrees per second per count in q.16, rounded to nearest
    function automatic logic [SCALE_W-1:0] scale_q16(input logic [1:0] sel);
        logic [SCALE_W-1:0] k;
        case (sel)
            2'd0:    k = 12'd500;
            2'd1:    k = 12'd1001;
            2'd2:    k = 12'd1998;
            default: k = 12'd3996;
        endcase
        return k;
    endfunction

endpackage

### design/gbcd_iter_unit.sv
// ----------------------------------------------------------------------------
// gbcd_iter_unit
// shared iterative unit: shift-add multiply, restoring divide, integer root
// ----------------------------------------------------------------------------
module gbcd_iter_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gbcd_pkg::unit_cmd_t    cmd_i,
    output gbcd_pkg::unit_stat_t   stat_o
);

    gbcd_pkg::unit_op_t                  op_reg;
    logic [gbcd_pkg::ACC_W-1:0]          acc_reg;
    logic [gbcd_pkg::DATA_W-1:0]         quo_reg;
    logic [gbcd_pkg::DATA_W-1:0]         dvd_reg;
    logic [gbcd_pkg::DATA_W-1:0]         opb_reg;
    logic [gbcd_pkg::STEP_W-1:0]         cnt_reg;
    logic                                busy_reg;
    logic                                done_reg;

    logic [gbcd_pkg::ACC_W-1:0]          a_op;
    logic [gbcd_pkg::ACC_W-1:0]          b_op;
    logic                                sub;
    logic [gbcd_pkg::ACC_W:0]            sum;
    logic                                fits;
    logic [gbcd_pkg::ACC_W-1:0]          acc_next;
    logic [gbcd_pkg::DATA_W-1:0]         quo_next;
    logic [gbcd_pkg::DATA_W-1:0]         dvd_next;

    // one adder serves every operation
    always_comb begin
        a_op = acc_reg;
        b_op = '0;
        sub  = 1'b0;
        case (op_reg)
            gbcd_pkg::OP_MUL: begin
                a_op = {acc_reg[gbcd_pkg::ACC_W-2:0], 1'b0};
                b_op = dvd_reg[gbcd_pkg::DATA_W-1] ?
                       {{(gbcd_pkg::ACC_W-gbcd_pkg::DATA_W){1'b0}}, opb_reg} : '0;
            end
            gbcd_pkg::OP_DIV: begin
                a_op = {acc_reg[gbcd_pkg::ACC_W-2:0], dvd_reg[gbcd_pkg::DATA_W-1]};
                b_op = {{(gbcd_pkg::ACC_W-gbcd_pkg::DATA_W){1'b0}}, opb_reg};
                sub  = 1'b1;
            end
            gbcd_pkg::OP_SQRT: begin
                a_op = {acc_reg[gbcd_pkg::ACC_W-3:0],
                        dvd_reg[gbcd_pkg::DATA_W-1:gbcd_pkg::DATA_W-2]};
                b_op = {quo_reg, 2'b01};
                sub  = 1'b1;
            end
            default: begin
                a_op = acc_reg;
                b_op = '0;
                sub  = 1'b0;
            end
        endcase
        sum  = {1'b0, a_op} + {1'b0, (sub ? ~b_op : b_op)} + {{gbcd_pkg::ACC_W{1'b0}}, sub};
        // carry out of the subtract means a >= b
        fits = sum[gbcd_pkg::ACC_W];
        acc_next = (!sub || fits) ? sum[gbcd_pkg::ACC_W-1:0] : a_op;
        quo_next = sub ? {quo_reg[gbcd_pkg::DATA_W-2:0], fits} : quo_reg;
        dvd_next = (op_reg == gbcd_pkg::OP_SQRT) ?
                   {dvd_reg[gbcd_pkg::DATA_W-3:0], 2'b00} :
                   {dvd_reg[gbcd_pkg::DATA_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= gbcd_pkg::OP_MUL;
        end else begin
            done_reg <= 1'b0;
            if (cmd_i.start) begin
                busy_reg <= 1'b1;
                op_reg   <= cmd_i.op;
                case (cmd_i.op)
                    gbcd_pkg::OP_MUL:  cnt_reg <= gbcd_pkg::STEP_W'(gbcd_pkg::CNT_W);
                    gbcd_pkg::OP_DIV:  cnt_reg <= gbcd_pkg::STEP_W'(gbcd_pkg::DATA_W);
                    gbcd_pkg::OP_SQRT: cnt_reg <= gbcd_pkg::STEP_W'(gbcd_pkg::VAR_W / 2);
                    default:           cnt_reg <= gbcd_pkg::STEP_W'(1);
                endcase
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == gbcd_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and result registers
    always_ff @(posedge aclk) begin
        if (cmd_i.start) begin
            acc_reg <= '0;
            quo_reg <= '0;
            opb_reg <= cmd_i.opb;
            case (cmd_i.op)
                gbcd_pkg::OP_MUL:
                    dvd_reg <= {cmd_i.opa[gbcd_pkg::CNT_W-1:0],
                                {(gbcd_pkg::DATA_W-gbcd_pkg::CNT_W){1'b0}}};
                gbcd_pkg::OP_SQRT:
                    dvd_reg <= {cmd_i.opa[gbcd_pkg::VAR_W-1:0],
                                {(gbcd_pkg::DATA_W-gbcd_pkg::VAR_W){1'b0}}};
                default:
                    dvd_reg <= cmd_i.opa;
            endcase
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            quo_reg <= quo_next;
            dvd_reg <= dvd_next;
        end
    end

    assign stat_o.busy = busy_reg;
    assign stat_o.done = done_reg;
    assign stat_o.acc  = acc_reg;
    assign stat_o.quo  = quo_reg;

endmodule

### design/gyro_bias_calibration_deadband_top.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibration_deadband_top
// three-axis gyro bias and noise calibration with dead-band and q.16 scaling
// ----------------------------------------------------------------------------
// measurement request: S_MA, S_MB per axis; result loaded in S_OUT before a new accept
// calibration request not ending a run: one axis accumulated per cycle in S_CAL
// run end: worked by the shared unit (48-step divides, 8-step multiply
//   and 16-step root, twice a divide per axis) over the three axes in turn
// aresetn synchronous active low: sums, bias, noise, flag cleared, calib_samples 50
// ----------------------------------------------------------------------------
`include "gyro_bias_calibration_deadband_top_macros.svh"

module gyro_bias_calibration_deadband_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [gbcd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [gbcd_pkg::CFG_W-1:0]           cfg_wr_data,
    // sample requests
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gbcd_pkg::S_TDATA_W-1:0]       s_tdata,   // raw_x, raw_y, raw_z
    input  logic [1:0]                           s_tuser,   // action
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gbcd_pkg::M_TDATA_W-1:0]       m_tdata,   // rate_x, rate_y, rate_z, pad
    output logic [1:0]                           m_tuser    // calib_done, is_calibrated
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CAL   = 11'b00000000010,
        S_FMAG  = 11'b00000000100,
        S_FSQ   = 11'b00000001000,
        S_FBIAS = 11'b00000010000,
        S_FMUL  = 11'b00000100000,
        S_FVAR  = 11'b00001000000,
        S_FSQRT = 11'b00010000000,
        S_MA    = 11'b00100000000,
        S_MB    = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    localparam logic [gbcd_pkg::AX_W-1:0] AX_LAST = gbcd_pkg::AX_W'(gbcd_pkg::NUM_AXES - 1);

    state_t                               state_reg;
    state_t                               state_next;
    logic [gbcd_pkg::AX_W-1:0]            ax_reg;

    // configuration
    logic [gbcd_pkg::CNT_W-1:0]           calib_samples_reg;
    logic [gbcd_pkg::CNT_W-1:0]           thr_mult_reg;
    logic [1:0]                           gyro_scale_reg;

    // calibration state
    logic signed [gbcd_pkg::SUM_W-1:0]    sum_reg   [gbcd_pkg::NUM_AXES];
    logic [gbcd_pkg::SQ_W-1:0]            sq_reg    [gbcd_pkg::NUM_AXES];
    logic signed [gbcd_pkg::RAW_W-1:0]    bias_reg  [gbcd_pkg::NUM_AXES];
    logic [gbcd_pkg::RAW_W-1:0]           noise_reg [gbcd_pkg::NUM_AXES];
    logic [gbcd_pkg::CNT_W-1:0]           count_reg;
    logic                                 calibrated_reg;

    // request capture and working registers
    gbcd_pkg::action_t                    action_in;
    logic signed [gbcd_pkg::RAW_W-1:0]    raw_reg   [gbcd_pkg::NUM_AXES];
    logic [gbcd_pkg::MAG_W-1:0]           mag_reg;
    logic                                 neg_reg;
    logic [gbcd_pkg::DATA_W-1:0]          ssq_reg;
    logic signed [gbcd_pkg::RAW_W:0]      d_reg;
    logic [gbcd_pkg::THR_W-1:0]           thr_reg;
    logic [gbcd_pkg::RATE_W-1:0]          rate_reg  [gbcd_pkg::NUM_AXES];
    logic                                 res_done_reg;

    // output register
    logic                                 m_tvalid_reg;
    logic [gbcd_pkg::M_TDATA_W-1:0]       m_tdata_reg;
    logic [1:0]                           m_tuser_reg;

    gbcd_pkg::unit_cmd_t                  unit_cmd;
    gbcd_pkg::unit_stat_t                 unit_stat;

    logic                                 s_accept;
    logic                                 out_free;
    logic                                 ax_last;
    logic [gbcd_pkg::CNT_W-1:0]           target;
    logic [gbcd_pkg::CNT_W:0]             count_inc;
    logic                                 run_end;

    logic signed [gbcd_pkg::RAW_W-1:0]    raw_sel;
    logic signed [gbcd_pkg::SUM_W-1:0]    sum_sel;
    logic [gbcd_pkg::SUM_W-1:0]           sum_abs;
    logic [gbcd_pkg::VAR_W-1:0]           raw_sq;
    logic [gbcd_pkg::MAG_W:0]             round_sum;
    logic [2*gbcd_pkg::CNT_W-1:0]         n_sq;
    logic [gbcd_pkg::DATA_W-1:0]          nsq;
    logic [gbcd_pkg::DATA_W-1:0]          var_num;
    logic [gbcd_pkg::RAW_W-1:0]           q_bias;
    logic signed [gbcd_pkg::RAW_W:0]      d_calc;
    logic signed [gbcd_pkg::SUM_W-1:0]    d_ext;
    logic signed [gbcd_pkg::SUM_W-1:0]    thr_pos;
    logic signed [gbcd_pkg::SUM_W-1:0]    thr_neg;
    logic                                 dead;
    logic signed [gbcd_pkg::RAW_W:0]      d_kept;
    logic signed [gbcd_pkg::SCALE_W:0]    k_s;
    logic signed [gbcd_pkg::RATE_W:0]     rate_prod;

    // shared multiply / divide / root unit
    gbcd_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (unit_cmd),
        .stat_o  (unit_stat)
    );

    // one request at a time; the output register lets the next request in
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign ax_last   = (ax_reg == AX_LAST);
    assign action_in = gbcd_pkg::action_t'(s_tuser);

    // a sample count of zero behaves as one
    assign target    = (calib_samples_reg == '0) ? gbcd_pkg::CNT_W'(1) : calib_samples_reg;
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign run_end   = (count_inc >= {1'b0, target});

    // per-axis selection, one axis at a time by ax_reg
    assign raw_sel   = raw_reg[ax_reg];
    assign sum_sel   = sum_reg[ax_reg];
    assign sum_abs   = sum_sel[gbcd_pkg::SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
    assign raw_sq    = gbcd_pkg::VAR_W'(raw_sel * raw_sel);

    // bias: (|sum| + n/2) / n, sign applied afterwards
    assign round_sum = {1'b0, mag_reg} +
                       {{(gbcd_pkg::MAG_W+1-gbcd_pkg::CNT_W){1'b0}}, (count_reg >> 1)};
    assign q_bias    = unit_stat.quo[gbcd_pkg::RAW_W-1:0];

    // variance numerator n*sumsq - sum^2, clamped at zero, over n^2
    assign n_sq      = count_reg * count_reg;
    assign nsq       = unit_stat.acc[gbcd_pkg::DATA_W-1:0];
    assign var_num   = (nsq >= ssq_reg) ? (nsq - ssq_reg) : '0;

    // measurement: bias removed once calibrated, then dead-band test in counts (off for a zero multiplier)
    assign d_calc    = {raw_sel[gbcd_pkg::RAW_W-1], raw_sel} -
                       (calibrated_reg ? {bias_reg[ax_reg][gbcd_pkg::RAW_W-1], bias_reg[ax_reg]}
                                       : '0);
    assign d_ext     = {{(gbcd_pkg::SUM_W-gbcd_pkg::RAW_W-1){d_reg[gbcd_pkg::RAW_W]}}, d_reg};
    assign thr_pos   = {1'b0, thr_reg};
    assign thr_neg   = -thr_pos;
    assign dead      = (thr_mult_reg != '0) && (d_ext > thr_neg) && (d_ext < thr_pos);
    assign d_kept    = dead ? '0 : d_reg;
    assign k_s       = {1'b0, gbcd_pkg::scale_q16(gyro_scale_reg)};
    assign rate_prod = d_kept * k_s;

    // sequencer and unit requests
    always_comb begin
        state_next = state_reg;
        unit_cmd   = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (action_in)
                        gbcd_pkg::ACT_CAL:  state_next = S_CAL;
                        gbcd_pkg::ACT_MEAS: state_next = S_MA;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_CAL: begin
                if (ax_last) begin
                    state_next = run_end ? S_FMAG : S_IDLE;
                end
            end
            S_FMAG: begin
                state_next = S_FSQ;
            end
            S_FSQ: begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = gbcd_pkg::OP_DIV;
                unit_cmd.opa   = {{(gbcd_pkg::DATA_W-gbcd_pkg::MAG_W-1){1'b0}}, round_sum};
                unit_cmd.opb   = {{(gbcd_pkg::DATA_W-gbcd_pkg::CNT_W){1'b0}}, count_reg};
                state_next     = S_FBIAS;
            end
            S_FBIAS: begin
                if (unit_stat.done) begin
                    unit_cmd.start = 1'b1;
                    unit_cmd.op    = gbcd_pkg::OP_MUL;
                    unit_cmd.opa   = {{(gbcd_pkg::DATA_W-gbcd_pkg::CNT_W){1'b0}}, count_reg};
                    unit_cmd.opb   = {{(gbcd_pkg::DATA_W-gbcd_pkg::SQ_W){1'b0}}, sq_reg[ax_reg]};
                    state_next     = S_FMUL;
                end
            end
            S_FMUL: begin
                if (unit_stat.done) begin
                    unit_cmd.start = 1'b1;
                    unit_cmd.op    = gbcd_pkg::OP_DIV;
                    unit_cmd.opa   = var_num;
                    unit_cmd.opb   = {{(gbcd_pkg::DATA_W-2*gbcd_pkg::CNT_W){1'b0}}, n_sq};
                    state_next     = S_FVAR;
                end
            end
            S_FVAR: begin
                if (unit_stat.done) begin
                    unit_cmd.start = 1'b1;
                    unit_cmd.op    = gbcd_pkg::OP_SQRT;
                    unit_cmd.opa   = unit_stat.quo;
                    state_next     = S_FSQRT;
                end
            end
            S_FSQRT: begin
                if (unit_stat.done) begin
                    state_next = ax_last ? S_OUT : S_FMAG;
                end
            end
            S_MA: begin
                state_next = S_MB;
            end
            S_MB: begin
                state_next = ax_last ? S_OUT : S_MA;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            ax_reg            <= '0;
            calib_samples_reg <= gbcd_pkg::CALIB_SAMPLES_RESET;
            thr_mult_reg      <= '0;
            gyro_scale_reg    <= '0;
            count_reg         <= '0;
            calibrated_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            for (int i = 0; i < gbcd_pkg::NUM_AXES; i++) begin
                sum_reg[i]   <= '0;
                sq_reg[i]    <= '0;
                bias_reg[i]  <= '0;
                noise_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    gbcd_pkg::REG_CALIB_SAMPLES: calib_samples_reg <= cfg_wr_data;
                    gbcd_pkg::REG_THRESHOLD:     thr_mult_reg      <= cfg_wr_data;
                    gbcd_pkg::REG_GYRO_SCALE:    gyro_scale_reg    <= cfg_wr_data[1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    ax_reg <= '0;
                    // restart drops the running sums but keeps bias and noise
                    if (s_accept && (action_in == gbcd_pkg::ACT_RESTART)) begin
                        count_reg <= '0;
                        for (int i = 0; i < gbcd_pkg::NUM_AXES; i++) begin
                            sum_reg[i] <= '0;
                            sq_reg[i]  <= '0;
                        end
                    end
                end
                S_CAL: begin
                    sum_reg[ax_reg] <= sum_reg[ax_reg] +
                        {{(gbcd_pkg::SUM_W-gbcd_pkg::RAW_W){raw_sel[gbcd_pkg::RAW_W-1]}}, raw_sel};
                    sq_reg[ax_reg]  <= sq_reg[ax_reg] +
                        {{(gbcd_pkg::SQ_W-gbcd_pkg::VAR_W){1'b0}}, raw_sq};
                    if (ax_last) begin
                        count_reg <= count_inc[gbcd_pkg::CNT_W-1:0];
                        ax_reg    <= '0;
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                S_FBIAS: begin
                    if (unit_stat.done) begin
                        bias_reg[ax_reg] <= neg_reg ? (~q_bias + 1'b1) : q_bias;
                    end
                end
                S_FSQRT: begin
                    if (unit_stat.done) begin
                        noise_reg[ax_reg] <= unit_stat.quo[gbcd_pkg::RAW_W-1:0];
                        if (ax_last) begin
                            // run complete: flag set, sums cleared for the next run
                            calibrated_reg <= 1'b1;
                            count_reg      <= '0;
                            for (int i = 0; i < gbcd_pkg::NUM_AXES; i++) begin
                                sum_reg[i] <= '0;
                                sq_reg[i]  <= '0;
                            end
                        end else begin
                            ax_reg <= ax_reg + 1'b1;
                        end
                    end
                end
                S_MB: begin
                    ax_reg <= ax_reg + 1'b1;
                end
                default: ;
            endcase

            if ((state_reg == S_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            raw_reg[0] <= s_tdata[gbcd_pkg::RAW_W-1:0];
            raw_reg[1] <= s_tdata[2*gbcd_pkg::RAW_W-1:gbcd_pkg::RAW_W];
            raw_reg[2] <= s_tdata[3*gbcd_pkg::RAW_W-1:2*gbcd_pkg::RAW_W];
        end
        case (state_reg)
            S_FMAG: begin
                mag_reg <= sum_abs[gbcd_pkg::MAG_W-1:0];
                neg_reg <= sum_sel[gbcd_pkg::SUM_W-1];
            end
            S_FSQ: begin
                ssq_reg <= gbcd_pkg::DATA_W'(mag_reg * mag_reg);
            end
            S_FSQRT: begin
                // run-end result carries zero rates
                if (unit_stat.done && ax_last) begin
                    res_done_reg <= 1'b1;
                    for (int i = 0; i < gbcd_pkg::NUM_AXES; i++) begin
                        rate_reg[i] <= '0;
                    end
                end
            end
            S_MA: begin
                d_reg   <= d_calc;
                thr_reg <= gbcd_pkg::THR_W'(noise_reg[ax_reg] * thr_mult_reg);
            end
            S_MB: begin
                rate_reg[ax_reg] <= rate_prod[gbcd_pkg::RATE_W-1:0];
                res_done_reg     <= 1'b0;
            end
            default: ;
        endcase
        if ((state_reg == S_OUT) && out_free) begin
            m_tdata_reg <= {{(gbcd_pkg::M_TDATA_W-gbcd_pkg::NUM_AXES*gbcd_pkg::RATE_W){1'b0}},
                            rate_reg[2], rate_reg[1], rate_reg[0]};
            m_tuser_reg <= {calibrated_reg, res_done_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // the sequencer never restarts the unit mid-operation
    `GBCD_ASSERT_SAME(a_start_free, unit_cmd.start, !unit_stat.busy, "unit request while busy")
    // no sample is taken while the unit is still iterating
    `GBCD_ASSERT_SAME(a_ready_quiet, s_tready, !unit_stat.busy, "ready with unit busy")
    // a run-end result carries zero rates and the calibrated flag
    `GBCD_ASSERT_SAME(a_done_zero, m_tvalid && m_tuser[0], (m_tdata == '0) && m_tuser[1],
        "run-end result not clean")
    // finishing the last axis clears the count and sets the flag
    `GBCD_ASSERT_NEXT(a_run_clears, (state_reg == S_FSQRT) && unit_stat.done && ax_last,
        (count_reg == '0) && calibrated_reg, "run end did not clear state")

endmodule
